@@ rtl/lcpt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpt_pkg
// Shared types and constants for the plane-averaged permittivity tensor block.
// ----------------------------------------------------------------------------
package lcpt_pkg;

   // Width of one field component, Q1.15.
   localparam int COMP_BITS   = 16;
   // Width of one permittivity entry, 16 fraction bits.
   localparam int TENSOR_BITS = 24;
   // Cycles from the accepting edge until the lanes hold the local tensor.
   localparam int LANE_CYCLES = 5;

   typedef logic signed [COMP_BITS-1:0]   comp_type;
   typedef logic signed [TENSOR_BITS-1:0] entry_type;

   // One tensor: xx, yy, zz, xy, xz, yz.
   typedef entry_type tensor_type [6];

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_EPS_ORDINARY = 3'd0,
      REG_EPS_ANISO    = 3'd1,
      REG_EPS_OUTSIDE  = 3'd2,
      REG_FIELD_MODE   = 3'd3,
      REG_PLANE_POINTS = 3'd4
   } reg_index_type;

   // Field modes.
   localparam logic MODE_DIRECTOR = 1'b0;
   localparam logic MODE_QTENSOR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_AVG
   } state_type;

   // Control from the sequencer to the plane store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   // Settings shared by all lanes.
   typedef struct packed {
      logic [22:0]        eps_ordinary;
      logic signed [23:0] eps_aniso;
      logic [22:0]        eps_outside;
      logic               field_mode;
      logic               inside_mask;
   } lane_cfg_type;

endpackage

@@ rtl/lcpt_lane.sv @@
// ----------------------------------------------------------------------------
// lcpt_lane
// One tensor entry: operand product or Q entry, scaling by the anisotropy,
// rounding, the divide by three of the Q form, the ordinary part, saturation and the mask.
// ----------------------------------------------------------------------------
module lcpt_lane (
   input  logic                  clock,
   input  logic                  is_diag,
   input  lcpt_pkg::lane_cfg_type cfg,
   input  lcpt_pkg::comp_type    op_i,
   input  lcpt_pkg::comp_type    op_j,
   input  lcpt_pkg::comp_type    op_q,
   output lcpt_pkg::entry_type   loc_out
);
   import lcpt_pkg::*;

   logic signed [31:0] nn;
   logic signed [32:0] q_ext;
   logic signed [32:0] x_in, x_ff;
   logic signed [56:0] prod_in, prod_ff;
   logic signed [56:0] dir_round;
   logic signed [56:0] q_round;
   logic        [26:0] val_in, val_ff;
   logic        [58:0] third;
   logic signed [26:0] r_in, r_ff;
   logic signed [27:0] sum;
   entry_type          loc_in, loc_ff;

   // Stage one: director product or scaled Q entry.
   always_comb begin
      nn    = op_i * op_j;
      q_ext = 33'(op_q);
      if (cfg.field_mode == MODE_DIRECTOR) begin
         x_in = 33'(nn);
      end else if (is_diag) begin
         x_in = (q_ext <<< 1) + 33'sd32768;
      end else begin
         x_in = q_ext <<< 1;
      end
   end

   // Stage two: times the anisotropy.
   assign prod_in = cfg.eps_aniso * x_ff;

   // Stage three: round to 16 fraction bits, or prepare the divide by three
   // with an offset that keeps the dividend positive.
   always_comb begin
      dir_round = (prod_ff + 57'sd536870912) >>> 30;
      q_round   = ((prod_ff <<< 1) + 57'sd98304) >>> 16;
      if (cfg.field_mode == MODE_DIRECTOR) begin
         val_in = dir_round[26:0];
      end else begin
         val_in = q_round[26:0] + 27'd100663296;
      end
   end

   // Stage four: reciprocal multiply for the divide by three.
   always_comb begin
      third = {32'd0, val_ff} * 59'h0AAAAAAAB;
      if (cfg.field_mode == MODE_DIRECTOR) begin
         r_in = signed'(val_ff);
      end else begin
         r_in = signed'(27'({1'b0, third[58:33]}) - 27'd33554432);
      end
   end

   // Stage five: add the ordinary part, saturate, apply the mask.
   always_comb begin
      sum = 28'(r_ff) + (is_diag ? signed'({5'd0, cfg.eps_ordinary}) : 28'sd0);
      if (!cfg.inside_mask) begin
         loc_in = is_diag ? signed'({1'b0, cfg.eps_outside}) : '0;
      end else if (sum > 28'sd8388607) begin
         loc_in = 24'sh7FFFFF;
      end else if (sum < -28'sd8388608) begin
         loc_in = 24'sh800000;
      end else begin
         loc_in = sum[23:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      val_ff  <= val_in;
      r_ff    <= r_in;
      loc_ff  <= loc_in;
   end

   assign loc_out = loc_ff;

endmodule

@@ rtl/lcpt_merge.sv @@
// ----------------------------------------------------------------------------
// lcpt_merge
// Plane store of local tensors and the average with the entry one plane back.
// ----------------------------------------------------------------------------
module lcpt_merge #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                   clock,
   input  lcpt_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          addr,
   input  lcpt_pkg::tensor_type   loc,
   output lcpt_pkg::tensor_type   avg
);
   import lcpt_pkg::*;

   logic [6*TENSOR_BITS-1:0] mem [DEPTH];
   logic [6*TENSOR_BITS-1:0] rd_ff;
   logic [6*TENSOR_BITS-1:0] wr_word;
   logic signed [TENSOR_BITS:0] s [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         wr_word[k*TENSOR_BITS +: TENSOR_BITS] = loc[k];
      end
   end

   // Store access: one read ahead of the write at the same position.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_ff <= mem[addr];
      end
      if (ctl.wr_en) begin
         mem[addr] <= wr_word;
      end
   end

   // Floor of (local + below + 1) / 2, always within range.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         s[k]   = 25'(loc[k]) + 25'(signed'(rd_ff[k*TENSOR_BITS +: TENSOR_BITS])) + 25'sd1;
         avg[k] = s[k][TENSOR_BITS:1];
      end
   end

endmodule

@@ rtl/lc_permittivity_tensor_plane_avg.sv @@
// ----------------------------------------------------------------------------
// lc_permittivity_tensor_plane_avg
// Local permittivity tensor per voxel, averaged with the voxel one plane back.
// ----------------------------------------------------------------------------
// Each voxel beat passes through the six entry lanes (multiply, scale,
// round, reciprocal divide by three, saturate) and then the averaging
// step, which averages with the plane store, writes the local tensor back
// and registers the result. Voxels are handled one at a time, so the input
// takes no new beat until the last one has left the averaging step, which
// a waiting result can hold; a result may wait on the output register while
// the next voxel is already taken. The first plane of each volume gives no
// result. The plane store has no reset; a read value is used only once the
// first plane of the volume has been written.
module lc_permittivity_tensor_plane_avg #(
   parameter int PLANE_POINTS_MAX = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lcpt_pkg::comp_type   req_comp_a,
   input  lcpt_pkg::comp_type   req_comp_b,
   input  lcpt_pkg::comp_type   req_comp_c,
   input  lcpt_pkg::comp_type   req_comp_d,
   input  lcpt_pkg::comp_type   req_comp_e,
   input  lcpt_pkg::comp_type   req_comp_f,
   input  logic                 req_inside_mask,
   input  logic                 req_volume_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lcpt_pkg::entry_type  rsp_tensor_xx,
   output lcpt_pkg::entry_type  rsp_tensor_yy,
   output lcpt_pkg::entry_type  rsp_tensor_zz,
   output lcpt_pkg::entry_type  rsp_tensor_xy,
   output lcpt_pkg::entry_type  rsp_tensor_xz,
   output lcpt_pkg::entry_type  rsp_tensor_yz
);
   import lcpt_pkg::*;

   localparam int AW = (PLANE_POINTS_MAX > 1) ? $clog2(PLANE_POINTS_MAX) : 1;
   localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
   localparam logic [CW-1:0] PMAX = CW'(PLANE_POINTS_MAX);

   // Configuration registers.
   logic [22:0]        eps_ordinary_ff;
   logic signed [23:0] eps_aniso_ff;
   logic [22:0]        eps_outside_ff;
   logic               field_mode_ff;
   logic [12:0]        plane_points_ff;

   // Accepted voxel.
   comp_type comp_ff [6];
   logic     mask_ff;

   state_type state_ff, state_in;
   logic [2:0] cnt_ff;
   logic [AW-1:0] pos_ff;
   logic          filled_ff;
   logic          rsp_valid_ff;
   tensor_type    rsp_ff;

   logic          accept;
   logic          out_free;
   logic          finish;
   logic [CW-1:0] pp_eff;
   logic [CW-1:0] pos_next;
   lane_cfg_type  cfg;
   store_ctl_type ctl;
   tensor_type    loc;
   tensor_type    avg;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_AVG) && (!filled_ff || out_free);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ordinary_ff <= 23'd147456;
         eps_aniso_ff    <= '0;
         eps_outside_ff  <= 23'd65536;
         field_mode_ff   <= MODE_DIRECTOR;
         plane_points_ff <= 13'd4096;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_EPS_ORDINARY: eps_ordinary_ff <= csr_wdata[22:0];
            REG_EPS_ANISO:    eps_aniso_ff    <= signed'(csr_wdata);
            REG_EPS_OUTSIDE:  eps_outside_ff  <= csr_wdata[22:0];
            REG_FIELD_MODE:   field_mode_ff   <= csr_wdata[0];
            REG_PLANE_POINTS: plane_points_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_CALC;
         ST_CALC: if (cnt_ff == 3'(LANE_CYCLES - 1)) state_in = ST_AVG;
         ST_AVG:  if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == ST_IDLE) && !reset;
      ctl.rd_en = (state_ff == ST_CALC) && (cnt_ff == 3'd0);
      ctl.wr_en = finish;
   end

   // Effective plane size and next position.
   always_comb begin
      if (plane_points_ff == 13'd0) begin
         pp_eff = CW'(1);
      end else if (CW'(plane_points_ff) > PMAX) begin
         pp_eff = PMAX;
      end else begin
         pp_eff = CW'(plane_points_ff);
      end
      pos_next = CW'(pos_ff) + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == ST_CALC) ? cnt_ff + 3'd1 : 3'd0;
         if (accept && req_volume_start) begin
            pos_ff    <= '0;
            filled_ff <= 1'b0;
         end else if (finish) begin
            if (pos_next >= pp_eff) begin
               pos_ff    <= '0;
               filled_ff <= 1'b1;
            end else begin
               pos_ff <= pos_next[AW-1:0];
            end
         end
         if (finish && filled_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Voxel and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         comp_ff[0] <= req_comp_a;
         comp_ff[1] <= req_comp_b;
         comp_ff[2] <= req_comp_c;
         comp_ff[3] <= req_comp_d;
         comp_ff[4] <= req_comp_e;
         comp_ff[5] <= req_comp_f;
         mask_ff    <= req_inside_mask;
      end
      if (finish && filled_ff) begin
         rsp_ff <= avg;
      end
   end

   always_comb begin
      cfg.eps_ordinary = eps_ordinary_ff;
      cfg.eps_aniso    = eps_aniso_ff;
      cfg.eps_outside  = eps_outside_ff;
      cfg.field_mode   = field_mode_ff;
      cfg.inside_mask  = mask_ff;
   end

   // Six lanes: diagonal entries, then xy, xz, yz.
   lcpt_lane u_lane_xx (.clock, .is_diag(1'b1), .cfg, .op_i(comp_ff[0]), .op_j(comp_ff[0]),
                        .op_q(comp_ff[0]), .loc_out(loc[0]));
   lcpt_lane u_lane_yy (.clock, .is_diag(1'b1), .cfg, .op_i(comp_ff[1]), .op_j(comp_ff[1]),
                        .op_q(comp_ff[1]), .loc_out(loc[1]));
   lcpt_lane u_lane_zz (.clock, .is_diag(1'b1), .cfg, .op_i(comp_ff[2]), .op_j(comp_ff[2]),
                        .op_q(comp_ff[2]), .loc_out(loc[2]));
   lcpt_lane u_lane_xy (.clock, .is_diag(1'b0), .cfg, .op_i(comp_ff[0]), .op_j(comp_ff[1]),
                        .op_q(comp_ff[3]), .loc_out(loc[3]));
   lcpt_lane u_lane_xz (.clock, .is_diag(1'b0), .cfg, .op_i(comp_ff[0]), .op_j(comp_ff[2]),
                        .op_q(comp_ff[4]), .loc_out(loc[4]));
   lcpt_lane u_lane_yz (.clock, .is_diag(1'b0), .cfg, .op_i(comp_ff[1]), .op_j(comp_ff[2]),
                        .op_q(comp_ff[5]), .loc_out(loc[5]));

   lcpt_merge #(.DEPTH(PLANE_POINTS_MAX), .AW(AW)) u_merge (
      .clock, .ctl, .addr(pos_ff), .loc, .avg
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tensor_xx = rsp_ff[0];
   assign rsp_tensor_yy = rsp_ff[1];
   assign rsp_tensor_zz = rsp_ff[2];
   assign rsp_tensor_xy = rsp_ff[3];
   assign rsp_tensor_xz = rsp_ff[4];
   assign rsp_tensor_yz = rsp_ff[5];

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Plane-averaged permittivity tensor testbench
// Streams voxel beats in director and Q-tensor mode across a range of
// permittivity and plane-size settings. A scoreboard predicts each averaged
// tensor, and every result beat is compared field by field. Both channels
// idle at random.
// ----------------------------------------------------------------------------
import lcpt_pkg::*;

// Predicts averaged tensors and checks the result beats against them.
class permittivity_scoreboard;
   longint            eps_ordinary, eps_aniso, eps_outside;
   logic              field_mode;
   int                plane_size;
   longint            below[6][4096];
   int                position;
   bit                filled;
   logic [5:0][23:0]  tensor_q[$];
   int                mismatches;

   function new();
      eps_ordinary = 147456;
      eps_aniso    = 0;
      eps_outside  = 65536;
      field_mode   = MODE_DIRECTOR;
      plane_size   = 4096;
      position     = 0;
      filled       = 0;
      mismatches   = 0;
   endfunction

   static function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   // Nearest, ties toward plus infinity.
   static function longint round_div(longint n, longint d);
      return floor_div(2 * n + d, 2 * d);
   endfunction

   static function longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function void write_reg(reg_index_type idx, logic [23:0] value);
      case (idx)
         REG_EPS_ORDINARY: eps_ordinary = longint'(value[22:0]);
         REG_EPS_ANISO:    eps_aniso = longint'($signed(value));
         REG_EPS_OUTSIDE:  eps_outside = longint'(value[22:0]);
         REG_FIELD_MODE:   field_mode = value[0];
         REG_PLANE_POINTS: begin
            plane_size = int'(value[12:0]);
            if (plane_size == 0) plane_size = 1;
            if (plane_size > 4096) plane_size = 4096;
         end
         default: ;
      endcase
   endfunction

   function int pending();
      return tensor_q.size();
   endfunction

   // Accepted voxel beat: form the local tensor and, past the first plane,
   // the expected average with the stored entry one plane back.
   function void note_voxel(comp_type comps[6], logic mask, logic vol_start);
      longint c[6];
      longint loc[6];
      int pi[3];
      int pj[3];
      logic [5:0][23:0] avg;
      pi = '{0, 0, 1};
      pj = '{1, 2, 2};
      for (int i = 0; i < 6; i++) c[i] = longint'(comps[i]);
      if (vol_start) begin
         position = 0;
         filled   = 0;
      end
      for (int i = 0; i < 3; i++) begin
         if (!mask) begin
            loc[i]     = sat24(eps_outside);
            loc[i + 3] = 0;
         end else if (field_mode == MODE_DIRECTOR) begin
            loc[i]     = sat24(eps_ordinary + round_div(eps_aniso * c[i] * c[i], 64'sd1 << 30));
            loc[i + 3] = sat24(round_div(eps_aniso * c[pi[i]] * c[pj[i]], 64'sd1 << 30));
         end else begin
            loc[i]     = sat24(eps_ordinary + round_div(eps_aniso * (32768 + 2 * c[i]),
                                                         3 * 32768));
            loc[i + 3] = sat24(round_div(eps_aniso * 2 * c[i + 3], 3 * 32768));
         end
      end
      if (filled) begin
         for (int i = 0; i < 6; i++)
            avg[i] = 24'(sat24(floor_div(loc[i] + below[i][position] + 1, 2)));
         tensor_q.push_back(avg);
      end
      for (int i = 0; i < 6; i++) below[i][position] = loc[i];
      position++;
      if (position >= plane_size) begin
         position = 0;
         filled   = 1;
      end
   endfunction

   function void check_tensor(logic [5:0][23:0] got);
      logic [5:0][23:0] want;
      if (tensor_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result beat %h", got);
         return;
      end
      want = tensor_q.pop_front();
      for (int i = 0; i < 6; i++) begin
         if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: entry %0d expected %0d got %0d", i,
                        $signed(want[i]), $signed(got[i]));
         end
      end
   endfunction
endclass

module testbench;
   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   comp_type    req_comp_a, req_comp_b, req_comp_c;
   comp_type    req_comp_d, req_comp_e, req_comp_f;
   logic        req_inside_mask;
   logic        req_volume_start;
   logic        rsp_valid;
   logic        rsp_ready;
   entry_type   rsp_tensor_xx, rsp_tensor_yy, rsp_tensor_zz;
   entry_type   rsp_tensor_xy, rsp_tensor_xz, rsp_tensor_yz;

   permittivity_scoreboard sb = new();
   int  voxels_sent;
   bit  no_idle;

   lc_permittivity_tensor_plane_avg DUT (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: stall in runs, mostly short, a few long.
   initial begin
      int hold;
      rsp_ready = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!rsp_ready) begin
            rsp_ready <= 1;
            hold = $urandom_range(0, 30);
         end else if (!no_idle) begin
            rsp_ready <= 0;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                               : $urandom_range(0, 3);
         end
      end
   end

   // Check every accepted result beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_tensor({rsp_tensor_yz, rsp_tensor_xz, rsp_tensor_xy,
                          rsp_tensor_zz, rsp_tensor_yy, rsp_tensor_xx});
   end

   task automatic write_reg(reg_index_type idx, logic [23:0] value);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_wdata    <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Drops the input, waits for every expected result and for the pipeline
   // to drain, then loads a full register set.
   task automatic configure(logic [23:0] ep, logic [23:0] ea, logic [23:0] eo,
                            logic mode, logic [23:0] points);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LANE_CYCLES + 12) @(posedge clock);
      write_reg(REG_EPS_ORDINARY, ep);
      write_reg(REG_EPS_ANISO, ea);
      write_reg(REG_EPS_OUTSIDE, eo);
      write_reg(REG_FIELD_MODE, {23'd0, mode});
      write_reg(REG_PLANE_POINTS, points);
      csr_write_en <= 0;
   endtask

   // Sends one voxel beat and returns on the edge that accepts it.
   task automatic send_voxel(comp_type a, comp_type b, comp_type c, comp_type d,
                             comp_type e, comp_type f, logic mask, logic vs);
      int gap;
      comp_type comps[6];
      gap = no_idle ? 0 : ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                        : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1;
      req_comp_a       <= a;
      req_comp_b       <= b;
      req_comp_c       <= c;
      req_comp_d       <= d;
      req_comp_e       <= e;
      req_comp_f       <= f;
      req_inside_mask  <= mask;
      req_volume_start <= vs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      comps = '{a, b, c, d, e, f};
      sb.note_voxel(comps, mask, vs);
      voxels_sent++;
   endtask

   function automatic comp_type pick_comp();
      case ($urandom_range(0, 19))
         0: return comp_type'(16'sh8000);
         1: return comp_type'(16'sh7FFF);
         2: return comp_type'(0);
         3: return comp_type'(-1);
         default: return comp_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_voxel(bit vs);
      send_voxel(pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                 pick_comp(), $urandom_range(0, 6) != 0,
                 vs || ($urandom_range(0, 39) == 0));
   endtask

   function automatic logic [23:0] pick_eps();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'h800000;
         3: return 24'h7FFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      int points, count;
      reset            = 1;
      csr_write_en     = 0;
      csr_index        = REG_EPS_ORDINARY;
      csr_wdata        = 0;
      req_valid        = 0;
      req_comp_a       = 0;
      req_comp_b       = 0;
      req_comp_c       = 0;
      req_comp_d       = 0;
      req_comp_e       = 0;
      req_comp_f       = 0;
      req_inside_mask  = 0;
      req_volume_start = 0;
      voxels_sent      = 0;
      no_idle          = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Director mode at the largest ordinary and anisotropy settings, two-voxel planes.
      configure(24'h7FFFFF, 24'h7FFFFF, 24'h000000, MODE_DIRECTOR, 24'd2);
      send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
      send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd1,
                 1'b1, 1'b0);
      send_voxel(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
      send_voxel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
      send_voxel(16'sh4000, -16'sh4000, 16'sh2000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
      send_voxel(-16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
      // A new volume mid-stream restarts the first plane.
      send_voxel(16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
      send_voxel(16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
      send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);

      // Q-tensor mode at the most negative anisotropy; plane size zero acts as one.
      configure(24'h000000, 24'h800000, 24'h7FFFFF, MODE_QTENSOR, 24'd0);
      send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 1'b1, 1'b1);
      send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 1'b1, 1'b0);
      send_voxel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
      send_voxel(-16'sh4000, 16'sh2AAA, 16'sd1, -16'sd1, 16'sh1234, -16'sh1234,
                 1'b1, 1'b0);
      send_voxel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
      send_voxel(16'sh7FFF, 16'sh8000, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b1, 1'b1);
      send_voxel(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);

      // Random phases, mostly small planes; each begins a new volume.
      while (voxels_sent < 1200) begin
         case ($urandom_range(0, 19))
            0:       points = 0;
            1, 2:    points = $urandom_range(9, 64);
            default: points = $urandom_range(1, 8);
         endcase
         configure(pick_eps(), pick_eps(), pick_eps(), 1'($urandom_range(0, 1)),
                   24'(points) | ($urandom_range(0, 1) ? 24'hFFE000 : 24'h0));
         no_idle = ($urandom_range(0, 4) == 0);
         if (points == 0) points = 1;
         count = 3 * points + $urandom_range(0, 20);
         for (int i = 0; i < count; i++) random_voxel(i == 0);
         no_idle = 0;
      end
      req_valid <= 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (LANE_CYCLES + 20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ lc_permittivity_tensor_plane_avg.f @@
rtl/lcpt_pkg.sv
rtl/lcpt_lane.sv
rtl/lcpt_merge.sv
rtl/lc_permittivity_tensor_plane_avg.sv
verif/testbench.sv
